// ===== sv/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants of the ARP cache and responder.
// ----------------------------------------------------------------------------
package arpc_pkg;

	localparam int CACHE_ENTRIES_DEF = 16;

	localparam int IP_W  = 32;
	localparam int MAC_W = 48;
	localparam int CFG_W = MAC_W;

	// operation codes of an input item
	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_PACKET = 1'b1;

	// configuration register indexes
	localparam logic CFG_OWN_IP  = 1'b0;
	localparam logic CFG_OWN_MAC = 1'b1;

	// ARP header checks
	localparam logic [15:0] ARP_HDR_BYTES = 16'd28;
	localparam logic [15:0] HW_ETHERNET   = 16'd1;
	localparam logic [15:0] PROTO_IPV4    = 16'h0800;
	localparam logic [15:0] ARP_OP_REQ    = 16'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_DONE
	} arpc_state_t;

	typedef struct packed {
		logic capture;
		logic scan_step;
		logic write_entry;
		logic load_out;
	} arpc_cmd_t;

	typedef struct packed {
		logic drop_now;
		logic is_packet;
		logic match;
		logic last;
		logic out_free;
	} arpc_status_t;

endpackage

// ===== sv/arp_cache_responder_top.sv =====
// ----------------------------------------------------------------------------
// arp_cache_responder_top
// ARP cache with round-robin replacement and request responder.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one transaction per lookup or
// received ARP packet; output channel (out_valid/out_stall) returns exactly
// one result per input transaction, in order.
// A lookup scans the cache from entry 0 and reports the first valid match.
// A packet that passes the header checks refreshes or inserts its sender
// pair, then yields reply fields if it is a request for own_ip.
// The cache RAM is scanned linearly, one entry per cycle through its
// registered read port, ending at the first match or at the last entry.
// A dropped packet skips the scan; a packet that passes the checks adds
// an entry write before its result is loaded. One transaction is in
// work at a time.
// The result register lets the next transaction be taken while a result
// waits; a stalled result holds until the receiver takes it.
// Reset clears all valid bits, the insert pointer and own_ip/own_mac.
// Write own_ip (index 0) and own_mac (index 1) only while idle.
// ----------------------------------------------------------------------------
module arp_cache_responder_top
	import arpc_pkg::*;
#(
	parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	input  logic [IP_W-1:0]    query_ip,
	input  logic [15:0]        packet_length,
	input  logic [15:0]        hw_type,
	input  logic [15:0]        prot_type,
	input  logic [15:0]        arp_opcode,
	input  logic [IP_W-1:0]    snd_ip,
	input  logic [MAC_W-1:0]   snd_mac,
	input  logic [IP_W-1:0]    tgt_ip,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               lookup_hit,
	output logic [MAC_W-1:0]   lookup_mac,
	output logic               packet_dropped,
	output logic               reply_valid,
	output logic [MAC_W-1:0]   reply_sender_mac,
	output logic [IP_W-1:0]    reply_sender_ip,
	output logic [MAC_W-1:0]   reply_target_mac,
	output logic [IP_W-1:0]    reply_target_ip
);

	arpc_cmd_t    cmd;
	arpc_status_t st;

	arpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	arpc_dpath #(
		.N (CACHE_ENTRIES)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.st               (st),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.operation        (operation),
		.query_ip         (query_ip),
		.packet_length    (packet_length),
		.hw_type          (hw_type),
		.prot_type        (prot_type),
		.arp_opcode       (arp_opcode),
		.snd_ip           (snd_ip),
		.snd_mac          (snd_mac),
		.tgt_ip           (tgt_ip),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.lookup_hit       (lookup_hit),
		.lookup_mac       (lookup_mac),
		.packet_dropped   (packet_dropped),
		.reply_valid      (reply_valid),
		.reply_sender_mac (reply_sender_mac),
		.reply_sender_ip  (reply_sender_ip),
		.reply_target_mac (reply_target_mac),
		.reply_target_ip  (reply_target_ip)
	);

endmodule

// ===== sv/arpc_ram.sv =====
// ----------------------------------------------------------------------------
// arpc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module arpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/arpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// arpc_ctrl
// Controller: sequences capture, cache scan, entry write and result load.
// ----------------------------------------------------------------------------
module arpc_ctrl
	import arpc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  arpc_status_t st,
	output arpc_cmd_t    cmd
);

	arpc_state_t state_q;
	arpc_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = st.drop_now ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (st.match || st.last) begin
					state_d = st.is_packet ? ST_WRITE : ST_DONE;
				end
			end
			ST_WRITE: state_d = ST_DONE;
			ST_DONE: begin
				if (st.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			ST_SCAN:  cmd.scan_step   = 1'b1;
			ST_WRITE: cmd.write_entry = 1'b1;
			ST_DONE:  cmd.load_out    = st.out_free;
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

// ===== sv/arpc_dpath.sv =====
// ----------------------------------------------------------------------------
// arpc_dpath
// Datapath: item registers, cache RAM and valid bits, scan compare,
// round-robin insert pointer, configuration and result registers.
// ----------------------------------------------------------------------------
module arpc_dpath
	import arpc_pkg::*;
#(
	parameter int N = CACHE_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  arpc_cmd_t          cmd,
	output arpc_status_t       st,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               operation,
	input  logic [IP_W-1:0]    query_ip,
	input  logic [15:0]        packet_length,
	input  logic [15:0]        hw_type,
	input  logic [15:0]        prot_type,
	input  logic [15:0]        arp_opcode,
	input  logic [IP_W-1:0]    snd_ip,
	input  logic [MAC_W-1:0]   snd_mac,
	input  logic [IP_W-1:0]    tgt_ip,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               lookup_hit,
	output logic [MAC_W-1:0]   lookup_mac,
	output logic               packet_dropped,
	output logic               reply_valid,
	output logic [MAC_W-1:0]   reply_sender_mac,
	output logic [IP_W-1:0]    reply_sender_ip,
	output logic [MAC_W-1:0]   reply_target_mac,
	output logic [IP_W-1:0]    reply_target_ip
);

	localparam int IW = $clog2(N);
	localparam int EW = IP_W + MAC_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(N - 1);

	// configuration
	logic [IP_W-1:0]  own_ip_q;
	logic [MAC_W-1:0] own_mac_q;

	// captured item
	logic             op_q;
	logic             drop_q;
	logic [IP_W-1:0]  key_q;
	logic [MAC_W-1:0] mac_q;
	logic [IP_W-1:0]  tip_q;
	logic [15:0]      opc_q;

	// scan and cache control
	logic [IW-1:0]    rd_addr_q;
	logic [IW-1:0]    rd_idx_s1;
	logic             rd_vld_s1;
	logic             hit_q;
	logic [IW-1:0]    hit_idx_q;
	logic [MAC_W-1:0] hit_mac_q;
	logic [N-1:0]     valid_q;
	logic [IW-1:0]    ins_q;
	logic             out_valid_q;

	logic [EW-1:0]    rdata;
	logic [IW-1:0]    waddr;
	logic             match;
	logic             reply_ok;

	arpc_ram #(
		.WIDTH (EW),
		.DEPTH (N)
	) u_cache (
		.clk   (clk),
		.we    (cmd.write_entry),
		.waddr (waddr),
		.wdata ({key_q, mac_q}),
		.raddr (rd_addr_q),
		.rdata (rdata)
	);

	assign waddr = hit_q ? hit_idx_q : ins_q;
	assign match = rd_vld_s1 && valid_q[rd_idx_s1] && (rdata[MAC_W +: IP_W] == key_q);

	assign st.drop_now  = (operation == OP_PACKET) &&
		((packet_length < ARP_HDR_BYTES) || (hw_type != HW_ETHERNET) ||
		 (prot_type != PROTO_IPV4));
	assign st.is_packet = (op_q == OP_PACKET);
	assign st.match     = match;
	assign st.last      = rd_vld_s1 && (rd_idx_s1 == LAST_IDX);
	assign st.out_free  = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q    <= '0;
			own_mac_q   <= '0;
			rd_vld_s1   <= 1'b0;
			hit_q       <= 1'b0;
			valid_q     <= '0;
			ins_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_OWN_IP) begin
					own_ip_q <= cfg_data[IP_W-1:0];
				end else begin
					own_mac_q <= cfg_data[MAC_W-1:0];
				end
			end
			if (cmd.capture) begin
				rd_vld_s1 <= 1'b0;
				hit_q     <= 1'b0;
			end else begin
				rd_vld_s1 <= cmd.scan_step;
				if (cmd.scan_step && match) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.write_entry) begin
				valid_q[waddr] <= 1'b1;
				if (!hit_q) begin
					ins_q <= (ins_q == LAST_IDX) ? '0 : ins_q + 1'b1;
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign reply_ok = (op_q == OP_PACKET) && !drop_q && (opc_q == ARP_OP_REQ) &&
		(tip_q == own_ip_q);

	// payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= operation;
			drop_q    <= st.drop_now;
			key_q     <= (operation == OP_LOOKUP) ? query_ip : snd_ip;
			mac_q     <= snd_mac;
			tip_q     <= tgt_ip;
			opc_q     <= arp_opcode;
			rd_addr_q <= '0;
		end else if (cmd.scan_step) begin
			rd_idx_s1 <= rd_addr_q;
			// hold at the last entry so the read stays in range
			if (rd_addr_q != LAST_IDX) begin
				rd_addr_q <= rd_addr_q + 1'b1;
			end
			if (match) begin
				hit_idx_q <= rd_idx_s1;
				hit_mac_q <= rdata[MAC_W-1:0];
			end
		end
		if (cmd.load_out) begin
			lookup_hit       <= (op_q == OP_LOOKUP) && hit_q;
			lookup_mac       <= ((op_q == OP_LOOKUP) && hit_q) ? hit_mac_q : '0;
			packet_dropped   <= (op_q == OP_PACKET) && drop_q;
			reply_valid      <= reply_ok;
			reply_sender_mac <= reply_ok ? own_mac_q : '0;
			reply_sender_ip  <= reply_ok ? own_ip_q : '0;
			reply_target_mac <= reply_ok ? mac_q : '0;
			reply_target_ip  <= reply_ok ? key_q : '0;
		end
	end

endmodule

// ===== sv/arpc_checker.sv =====
// ----------------------------------------------------------------------------
// arpc_checker
// Port-level checks of the ARP cache and responder, bound to the top level.
// ----------------------------------------------------------------------------
module arpc_checker
	import arpc_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic             lookup_hit,
	input logic [MAC_W-1:0] lookup_mac,
	input logic             packet_dropped,
	input logic             reply_valid,
	input logic [MAC_W-1:0] reply_sender_mac,
	input logic [IP_W-1:0]  reply_sender_ip,
	input logic [MAC_W-1:0] reply_target_mac,
	input logic [IP_W-1:0]  reply_target_ip
);

	// one transaction in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after a transaction");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(lookup_mac) &&
		$stable(reply_target_ip))
		else $error("stalled result changed");

	a_kinds_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(lookup_hit && (packet_dropped || reply_valid)) &&
		!(packet_dropped && reply_valid))
		else $error("result mixes lookup, drop and reply");

	a_miss_mac_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !lookup_hit |-> lookup_mac == '0)
		else $error("lookup_mac set without a hit");

	a_no_reply_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !reply_valid |-> reply_sender_mac == '0 &&
		reply_sender_ip == '0 && reply_target_mac == '0 && reply_target_ip == '0)
		else $error("reply fields set without a reply");

endmodule

bind arp_cache_responder_top arpc_checker u_arpc_checker (.*);
